### hw/rtl/cmft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback tracker package
// Shared constants and types for the multi-turn encoder tracker.
// ----------------------------------------------------------------------------
package cmft_pkg;

  localparam int MOTORS_DEFAULT       = 8;
  localparam int SMALL_MOTORS_DEFAULT = 4;
  localparam int SLOT_W               = 3;

  localparam logic [10:0] ID_BASE   = 11'h200;
  localparam logic [15:0] HALF_TURN = 16'd4096;
  localparam logic [15:0] PPR_RESET = 16'd8191;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_ZERO  = 1'b1
  } op_t;

  typedef struct packed {
    logic [15:0] angle;
    logic [31:0] count;
  } entry_t;

endpackage

### hw/rtl/can_motor_feedback_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback tracker
// Unwraps raw rotor angles from motor feedback frames into per-slot
// multi-turn counts.
//
// The input channel (in_valid / in_ready) carries either a feedback frame or
// a zero request; the output channel (out_valid / out_ready) returns exactly
// one result for each input transfer, in order. Frames that are extended,
// remote or outside the slot identifier range return an all-zero result.
// The per-slot angle and count live in a small synchronous memory that is
// read when a transfer is taken and written back from the read stage; the
// most recent write is forwarded, so items for the same slot may follow in
// consecutive cycles. out_valid rises as an item enters the result register;
// one item is taken every cycle while the receiver keeps up. When out_ready
// is low the result register holds and one more item may wait in the read
// stage before in_ready drops. Reset clears all pipeline valids, marks every
// slot as invalid and zero-pending, and restores pulses_per_round to 8191;
// no clearing pass is needed. The user must write the register through
// cfg_we / cfg_wdata only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module can_motor_feedback_tracker_unit #(
  parameter int MOTORS       = cmft_pkg::MOTORS_DEFAULT,
  parameter int SMALL_MOTORS = cmft_pkg::SMALL_MOTORS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [2:0]         motor_select,
  input  logic               extended_id,
  input  logic               remote_frame,
  input  logic [10:0]        std_id,
  input  logic signed [15:0] angle_word,
  input  logic signed [15:0] speed_word,
  input  logic signed [15:0] current_word,
  input  logic signed [7:0]  temperature_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               accepted,
  output logic [2:0]         slot,
  output logic signed [31:0] total_count,
  output logic signed [15:0] speed_out,
  output logic signed [15:0] current_out,
  output logic signed [7:0]  temperature_out,
  output logic               temperature_valid
);

  localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam logic [10:0] ID_FIRST = 11'(cmft_pkg::ID_BASE + 11'd1);
  localparam logic [10:0] ID_LAST  = 11'(cmft_pkg::ID_BASE + 11'(MOTORS));
  localparam logic [3:0]  MOTORS_N = 4'(MOTORS);
  localparam logic [3:0]  SMALL_N  = 4'(SMALL_MOTORS);

  logic [15:0] pulses_per_round;

  cmft_pkg::entry_t mem [MOTORS];
  cmft_pkg::entry_t rd_data;
  logic [MOTORS-1:0] entry_valid;
  logic [MOTORS-1:0] zero_pending;

  logic             in_xfer;
  logic             in_hit;
  logic             in_zero;
  logic [10:0]      id_off;
  logic [cmft_pkg::SLOT_W-1:0] in_slot;

  logic             s1_valid;
  logic             s1_hit;
  logic             s1_zero;
  logic [cmft_pkg::SLOT_W-1:0] s1_slot;
  logic [15:0]      s1_angle;
  logic [15:0]      s1_speed;
  logic [15:0]      s1_current;
  logic [7:0]       s1_temp;
  logic             s1_adv;

  logic             fwd_valid;
  logic [cmft_pkg::SLOT_W-1:0] fwd_slot;
  cmft_pkg::entry_t fwd_data;

  cmft_pkg::entry_t cur;
  cmft_pkg::entry_t wr_data;
  logic             wr_en;
  logic [15:0]      gap_raw;
  logic [15:0]      gap;
  logic [31:0]      count_next;
  logic             temp_en;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    id_off  = 11'(std_id - ID_FIRST);
    in_zero = (cmft_pkg::op_t'(operation) == cmft_pkg::OP_ZERO) &&
              ({1'b0, motor_select} < MOTORS_N);
    in_hit  = (cmft_pkg::op_t'(operation) == cmft_pkg::OP_FRAME) && !extended_id &&
              !remote_frame && (std_id >= ID_FIRST) && (std_id <= ID_LAST);
    in_slot = in_zero ? motor_select : id_off[cmft_pkg::SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_round <= cmft_pkg::PPR_RESET;
    end else if (cfg_we) begin
      pulses_per_round <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= mem[in_slot[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[s1_slot[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_hit     <= in_hit;
      s1_zero    <= in_zero;
      s1_slot    <= in_slot;
      s1_angle   <= angle_word;
      s1_speed   <= speed_word;
      s1_current <= current_word;
      s1_temp    <= temperature_byte;
    end
  end

  always_comb begin
    if (fwd_valid && (fwd_slot == s1_slot)) begin
      cur = fwd_data;
    end else if (entry_valid[s1_slot[IDX_W-1:0]]) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    gap_raw = 16'(s1_angle - cur.angle);
    if ($signed(gap_raw) > $signed(cmft_pkg::HALF_TURN)) begin
      gap = 16'(gap_raw - pulses_per_round);
    end else if ($signed(gap_raw) < -$signed(cmft_pkg::HALF_TURN)) begin
      gap = 16'(gap_raw + pulses_per_round);
    end else begin
      gap = gap_raw;
    end
    if (zero_pending[s1_slot[IDX_W-1:0]]) begin
      count_next = '0;
    end else begin
      count_next = 32'(cur.count + {{16{gap[15]}}, gap});
    end
    wr_en = s1_adv && (s1_hit || s1_zero);
    if (s1_zero) begin
      wr_data.angle = cur.angle;
      wr_data.count = '0;
    end else begin
      wr_data.angle = s1_angle;
      wr_data.count = count_next;
    end
    temp_en = s1_hit && ({1'b0, s1_slot} >= SMALL_N);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid    <= 1'b0;
      entry_valid  <= '0;
      zero_pending <= '1;
    end else if (wr_en) begin
      fwd_valid                          <= 1'b1;
      entry_valid[s1_slot[IDX_W-1:0]]    <= 1'b1;
      zero_pending[s1_slot[IDX_W-1:0]]   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_slot <= s1_slot;
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      accepted          <= s1_hit || s1_zero;
      slot              <= (s1_hit || s1_zero) ? s1_slot : '0;
      total_count       <= s1_hit ? count_next : '0;
      speed_out         <= s1_hit ? s1_speed : '0;
      current_out       <= s1_hit ? s1_current : '0;
      temperature_out   <= temp_en ? s1_temp : '0;
      temperature_valid <= temp_en;
    end
  end

  a_pending_cleared: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !zero_pending[$past(s1_slot[IDX_W-1:0])])
    else $error("zero pending flag not cleared after slot update");

  a_reset_pending: assert property (@(posedge clk)
    rst |=> (zero_pending == '1) && !out_valid && !s1_valid)
    else $error("reset state not established");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (total_count == '0) && (speed_out == '0) &&
                                 (current_out == '0) && !temperature_valid)
    else $error("rejected item carries nonzero fields");

  a_temp_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && temperature_valid) |-> ({1'b0, slot} >= SMALL_N) && accepted)
    else $error("temperature reported for a small motor slot");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback tracker testbench
// Drives feedback frames and zero requests through the valid/ready input
// channel and predicts every result with its own copy of the per-slot angle,
// count and pending-zero state. Each output transfer is compared field by
// field with the oldest prediction. Directed tests cover first frames,
// rejected frames, angle wraps and zero requests; random traffic then runs
// under several pulses-per-round settings with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    cmft_pkg::op_t      op;
    logic [2:0]         sel;
    logic               ext;
    logic               rtr;
    logic [10:0]        id;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic signed [7:0]  temp;
  } feedback_t;

  typedef struct {
    logic               accepted;
    logic [2:0]         slot_idx;
    logic signed [31:0] count;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic signed [7:0]  temp;
    logic               temp_valid;
  } tracker_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = 1'b0;
  logic [2:0]         motor_select = '0;
  logic               extended_id = 1'b0;
  logic               remote_frame = 1'b0;
  logic [10:0]        std_id = '0;
  logic signed [15:0] angle_word = '0;
  logic signed [15:0] speed_word = '0;
  logic signed [15:0] current_word = '0;
  logic signed [7:0]  temperature_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               accepted;
  logic [2:0]         slot;
  logic signed [31:0] total_count;
  logic signed [15:0] speed_out;
  logic signed [15:0] current_out;
  logic signed [7:0]  temperature_out;
  logic               temperature_valid;

  logic [15:0] last_angle [8];
  logic [31:0] turn_total [8];
  logic        zero_flag [8];
  logic [15:0] model_ppr;

  tracker_result_t tracker_results_q [$];
  int  mismatch_count = 0;
  bit  sender_gaps = 1'b1;
  bit  receiver_stalls = 1'b1;
  int  stall_left = 0;

  can_motor_feedback_tracker_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .motor_select(motor_select),
    .extended_id(extended_id),
    .remote_frame(remote_frame),
    .std_id(std_id),
    .angle_word(angle_word),
    .speed_word(speed_word),
    .current_word(current_word),
    .temperature_byte(temperature_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accepted(accepted),
    .slot(slot),
    .total_count(total_count),
    .speed_out(speed_out),
    .current_out(current_out),
    .temperature_out(temperature_out),
    .temperature_valid(temperature_valid)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic tracker_result_t unwrap_step(input feedback_t f);
    tracker_result_t    r;
    int                 s;
    logic signed [15:0] step;
    r = '{default: '0};
    if (f.op == cmft_pkg::OP_ZERO) begin
      if (int'(f.sel) >= cmft_pkg::MOTORS_DEFAULT) return r;
      turn_total[f.sel] = '0;
      zero_flag[f.sel] = 1'b0;
      r.accepted = 1'b1;
      r.slot_idx = f.sel;
      return r;
    end
    if (f.ext || f.rtr || f.id <= cmft_pkg::ID_BASE ||
        int'(f.id) > int'(cmft_pkg::ID_BASE) + cmft_pkg::MOTORS_DEFAULT)
      return r;
    s = int'(f.id) - int'(cmft_pkg::ID_BASE) - 1;
    step = f.angle - last_angle[s];
    if (int'(step) > int'(cmft_pkg::HALF_TURN)) begin
      step = step - model_ppr;
    end else if (int'(step) < -int'(cmft_pkg::HALF_TURN)) begin
      step = step + model_ppr;
    end
    turn_total[s] = turn_total[s] + {{16{step[15]}}, step};
    if (zero_flag[s]) begin
      turn_total[s] = '0;
      zero_flag[s] = 1'b0;
    end
    last_angle[s] = f.angle;
    r.accepted = 1'b1;
    r.slot_idx = 3'(s);
    r.count = turn_total[s];
    r.speed = f.speed;
    r.current = f.current;
    if (s + 1 > cmft_pkg::SMALL_MOTORS_DEFAULT) begin
      r.temp = f.temp;
      r.temp_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic feedback_t frame_item(input int s, input logic [15:0] angle,
                                           input logic [15:0] speed,
                                           input logic [15:0] current,
                                           input logic [7:0] temp);
    feedback_t f;
    f.op = cmft_pkg::OP_FRAME;
    f.sel = 3'($urandom_range(0, 7));
    f.ext = 1'b0;
    f.rtr = 1'b0;
    f.id = cmft_pkg::ID_BASE + 11'(s + 1);
    f.angle = angle;
    f.speed = speed;
    f.current = current;
    f.temp = temp;
    return f;
  endfunction

  function automatic feedback_t zero_item(input int sel);
    feedback_t f;
    f = frame_item($urandom_range(0, 7), 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom));
    f.op = cmft_pkg::OP_ZERO;
    f.sel = 3'(sel);
    f.id = 11'($urandom_range(0, 2047));
    f.ext = 1'($urandom_range(0, 1));
    f.rtr = 1'($urandom_range(0, 1));
    return f;
  endfunction

  function automatic feedback_t random_feedback();
    feedback_t f;
    int        s;
    int        r;
    int        delta;
    s = $urandom_range(0, 7);
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: delta = $urandom_range(0, 8192) - 4096;
      1: delta = $urandom_range(0, 1) ? $urandom_range(4097, 32768)
                                      : -$urandom_range(4097, 32768);
      default: delta = $urandom_range(0, 65535);
    endcase
    f = frame_item(s, last_angle[s] + 16'(delta), 16'($urandom), 16'($urandom),
                   8'($urandom));
    if (r >= 65 && r < 73) begin
      f = zero_item(s);
    end else if (r >= 73 && r < 85) begin
      f.ext = 1'($urandom_range(0, 1));
      f.rtr = ~f.ext | 1'($urandom_range(0, 1));
    end else if (r >= 85) begin
      f.id = 11'($urandom_range(0, 2047));
      f.ext = 1'($urandom_range(0, 1));
      f.rtr = 1'($urandom_range(0, 1));
    end
    return f;
  endfunction

  task automatic send_item(input feedback_t f);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= f.op;
    motor_select <= f.sel;
    extended_id <= f.ext;
    remote_frame <= f.rtr;
    std_id <= f.id;
    angle_word <= f.angle;
    speed_word <= f.speed;
    current_word <= f.current;
    temperature_byte <= f.temp;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker_results_q.push_back(unwrap_step(f));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pulses_per_round(input logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_ppr = value;
  endtask

  task automatic test_first_frames();
    for (int s = 0; s < cmft_pkg::MOTORS_DEFAULT; s++)
      send_item(frame_item(s, 16'($urandom), 16'($urandom), 16'($urandom),
                           8'($urandom)));
  endtask

  task automatic test_rejected_frames();
    feedback_t f;
    f = frame_item(2, 16'h1234, 16'h7FFF, 16'h8000, 8'h7F);
    f.ext = 1'b1;
    send_item(f);
    f = frame_item(6, 16'h4321, 16'h8000, 16'h7FFF, 8'h80);
    f.rtr = 1'b1;
    send_item(f);
    f.rtr = 1'b0;
    f.id = cmft_pkg::ID_BASE;
    send_item(f);
    f.id = cmft_pkg::ID_BASE + 11'(cmft_pkg::MOTORS_DEFAULT + 1);
    send_item(f);
    f.id = 11'h000;
    send_item(f);
    f.id = 11'h7FF;
    f.ext = 1'b1;
    f.rtr = 1'b1;
    send_item(f);
  endtask

  task automatic test_angle_wraps();
    send_item(frame_item(5, 16'h0000, 16'h7FFF, 16'h8000, 8'h7F));
    send_item(frame_item(5, 16'd4096, 16'h8000, 16'h7FFF, 8'h80));
    send_item(frame_item(5, 16'd8193, 16'hFFFF, 16'h0000, 8'hFF));
    send_item(frame_item(5, 16'd4096, 16'h0000, 16'hFFFF, 8'h00));
    send_item(frame_item(5, 16'h0000, 16'($urandom), 16'($urandom), 8'($urandom)));
    send_item(frame_item(5, 16'h8000, 16'($urandom), 16'($urandom), 8'($urandom)));
    send_item(frame_item(5, 16'h0000, 16'($urandom), 16'($urandom), 8'($urandom)));
    send_item(frame_item(1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h7F));
  endtask

  task automatic test_zero_requests();
    send_item(zero_item(0));
    send_item(zero_item(3));
    send_item(zero_item(4));
    send_item(zero_item(7));
    send_item(frame_item(7, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)));
  endtask

  task automatic test_random_traffic(input logic [15:0] ppr, input int items);
    set_pulses_per_round(ppr);
    for (int i = 0; i < items; i++) begin
      if (i % 75 == 0) begin
        sender_gaps = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 199) == 0) wait_drained();
      send_item(random_feedback());
    end
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (receiver_stalls) stall_left = pick_gap();
      end
    end
  end

  task automatic compare_field(input string name, input logic signed [31:0] e,
                               input logic signed [31:0] a);
    if (a !== e) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    tracker_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (tracker_results_q.size() == 0) begin
        $display("%0t: result transfer with no expectation waiting, slot %0d count %0d",
                 $time, slot, total_count);
        mismatch_count++;
      end else begin
        e = tracker_results_q.pop_front();
        compare_field("accepted", e.accepted, accepted);
        compare_field("slot", e.slot_idx, slot);
        compare_field("total_count", e.count, total_count);
        compare_field("speed_out", e.speed, speed_out);
        compare_field("current_out", e.current, current_out);
        compare_field("temperature_out", e.temp, temperature_out);
        compare_field("temperature_valid", e.temp_valid, temperature_valid);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int s = 0; s < 8; s++) begin
      last_angle[s] = '0;
      turn_total[s] = '0;
      zero_flag[s] = 1'b1;
    end
    model_ppr = cmft_pkg::PPR_RESET;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_first_frames();
    test_rejected_frames();
    test_angle_wraps();
    test_zero_requests();
    test_random_traffic(16'd1, 225);
    test_random_traffic(16'hFFFF, 225);
    test_random_traffic(16'd0, 225);
    test_random_traffic(16'd8192, 225);
    test_random_traffic(16'($urandom_range(1, 65535)), 225);
    test_random_traffic(cmft_pkg::PPR_RESET, 225);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cmft_pkg.sv
hw/rtl/can_motor_feedback_tracker_unit.sv
tb/tb.sv
